// ===== rtl/rvp_pkg.sv =====
// Shared types and stage counts for the radial vignette pixel unit.
// No dependencies.
package rvp_pkg;

    localparam int DIST_STAGES = 3;
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 16;
    localparam int RATIO_LAT   = DIST_STAGES + SQRT_STAGES + DIV_STAGES;

    localparam int LOG_STAGES  = 16;
    localparam int EXP_STAGES  = 16;
    localparam int POWER_LAT   = LOG_STAGES + EXP_STAGES + 3;

    localparam logic [16:0] Q16_ONE = 17'h10000;

    typedef struct packed {
        logic        vld;
        logic [16:0] q;
    } t_ratio;

    typedef struct packed {
        logic        vld;
        logic [16:0] p;
    } t_power;

endpackage

// ===== rtl/rvp_ratio.sv =====
// Distance to centre, square root and divide by radius: Q16 ratio clamped to 1.
// Depends on rvp_pkg.
module rvp_ratio #(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_pos_x,
    input  logic [COORD_BITS-1:0] i_pos_y,
    input  logic signed [16:0]    i_center_x,
    input  logic signed [16:0]    i_center_y,
    input  logic [16:0]           i_radius,
    output rvp_pkg::t_ratio       o_ratio
);
    localparam int PW   = COORD_BITS + 5;
    localparam int DW   = ((PW > 17) ? PW : 17) + 1;
    localparam int AW   = DW - 1;
    localparam int D2W  = 2 * AW + 1;
    localparam int SQ_N = rvp_pkg::SQRT_STAGES;
    localparam int DV_N = rvp_pkg::DIV_STAGES;

    // stage A: offsets
    logic signed [DW-1:0] n_dx, n_dy;
    logic                 r_a_vld;
    logic [AW-1:0]        r_adx, r_ady;

    always_comb begin
        n_dx = DW'(signed'({1'b0, i_pos_x, 4'b0000})) - DW'(i_center_x);
        n_dy = DW'(signed'({1'b0, i_pos_y, 4'b0000})) - DW'(i_center_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= i_valid;
        end
        r_adx <= n_dx[DW-1] ? AW'(-n_dx) : AW'(n_dx);
        r_ady <= n_dy[DW-1] ? AW'(-n_dy) : AW'(n_dy);
    end

    // stage B: squares
    logic            r_b_vld;
    logic [2*AW-1:0] r_sqx, r_sqy;
    logic [33:0]     r_rr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_sqx <= (2*AW)'(r_adx) * (2*AW)'(r_adx);
        r_sqy <= (2*AW)'(r_ady) * (2*AW)'(r_ady);
        r_rr  <= 34'(i_radius) * 34'(i_radius);
    end

    // stage C: sum, saturate test, sqrt argument
    logic [D2W-1:0] n_d2;
    logic           n_full;
    logic           r_c_vld, r_c_full;
    logic [63:0]    r_c_arg;

    always_comb begin
        n_d2   = D2W'(r_sqx) + D2W'(r_sqy);
        n_full = (i_radius == 17'd0) || (n_d2 >= D2W'(r_rr));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c_full <= n_full;
        r_c_arg  <= {n_d2[33:0], 30'd0};
    end

    // square root, one result bit per stage
    logic        w_sq_vld  [0:SQ_N];
    logic        w_sq_full [0:SQ_N];
    logic [63:0] w_sq_rem  [0:SQ_N];
    logic [31:0] w_sq_root [0:SQ_N];

    assign w_sq_vld[0]  = r_c_vld;
    assign w_sq_full[0] = r_c_full;
    assign w_sq_rem[0]  = r_c_arg;
    assign w_sq_root[0] = '0;

    for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
        localparam int B = SQ_N - 1 - k;
        logic [63:0] n_trial;
        logic        n_ge;
        logic        r_vld, r_full;
        logic [63:0] r_rem;
        logic [31:0] r_root;

        always_comb begin
            n_trial = (64'(w_sq_root[k]) << (B + 1)) | (64'd1 << (2 * B));
            n_ge    = w_sq_rem[k] >= n_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_sq_vld[k];
            end
            r_full <= w_sq_full[k];
            r_rem  <= n_ge ? (w_sq_rem[k] - n_trial) : w_sq_rem[k];
            r_root <= n_ge ? (w_sq_root[k] | (32'd1 << B)) : w_sq_root[k];
        end

        assign w_sq_vld[k+1]  = r_vld;
        assign w_sq_full[k+1] = r_full;
        assign w_sq_rem[k+1]  = r_rem;
        assign w_sq_root[k+1] = r_root;
    end

    // restoring divide of 2*root by radius
    logic        w_dv_vld  [0:DV_N];
    logic        w_dv_full [0:DV_N];
    logic [32:0] w_dv_rem  [0:DV_N];
    logic [15:0] w_dv_q    [0:DV_N];

    assign w_dv_vld[0]  = w_sq_vld[SQ_N];
    assign w_dv_full[0] = w_sq_full[SQ_N];
    assign w_dv_rem[0]  = {w_sq_root[SQ_N], 1'b0};
    assign w_dv_q[0]    = '0;

    for (genvar j = 0; j < DV_N; j++) begin : g_div
        localparam int J = DV_N - 1 - j;
        logic [32:0] n_dvs;
        logic        n_ge;
        logic        r_vld, r_full;
        logic [32:0] r_rem;
        logic [15:0] r_q;

        always_comb begin
            n_dvs = 33'(i_radius) << J;
            n_ge  = w_dv_rem[j] >= n_dvs;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_dv_vld[j];
            end
            r_full <= w_dv_full[j];
            r_rem  <= n_ge ? (w_dv_rem[j] - n_dvs) : w_dv_rem[j];
            r_q    <= n_ge ? (w_dv_q[j] | (16'd1 << J)) : w_dv_q[j];
        end

        assign w_dv_vld[j+1]  = r_vld;
        assign w_dv_full[j+1] = r_full;
        assign w_dv_rem[j+1]  = r_rem;
        assign w_dv_q[j+1]    = r_q;
    end

    assign o_ratio.vld = w_dv_vld[DV_N];
    assign o_ratio.q   = w_dv_full[DV_N] ? rvp_pkg::Q16_ONE : {1'b0, w_dv_q[DV_N]};

endmodule

// ===== rtl/rvp_power.sv =====
// Ratio raised to the softness exponent: log2 by repeated squaring, then exp2.
// Depends on rvp_pkg.
module rvp_power (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rvp_pkg::t_ratio i_ratio,
    input  logic [11:0]     i_softness,
    output rvp_pkg::t_power o_power
);
    localparam int LG_N = rvp_pkg::LOG_STAGES;
    localparam int EX_N = rvp_pkg::EXP_STAGES;

    // c_j = 2^(-2^-j) in Q30
    function automatic logic [29:0] exp_coef(input int j);
        logic [63:0] c, x, r, b;
        c = 64'd1 << 29;
        for (int s = 1; s <= j; s++) begin
            x = c << 30;
            r = '0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            c = r;
        end
        return c[29:0];
    endfunction

    // normalise
    logic [3:0]  n_lead;
    logic        r_n_vld, r_n_zero, r_n_one;
    logic [3:0]  r_n_lead;
    logic [30:0] r_n_x;

    always_comb begin
        n_lead = '0;
        for (int i = 0; i < 16; i++) begin
            if (i_ratio.q[i]) begin
                n_lead = 4'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else begin
            r_n_vld <= i_ratio.vld;
        end
        r_n_zero <= i_ratio.q == 17'd0;
        r_n_one  <= i_ratio.q[16];
        r_n_lead <= n_lead;
        r_n_x    <= 31'(i_ratio.q[15:0]) << (5'd30 - 5'(n_lead));
    end

    // log2 fraction bits
    logic        w_lg_vld  [0:LG_N];
    logic        w_lg_zero [0:LG_N];
    logic        w_lg_one  [0:LG_N];
    logic [3:0]  w_lg_lead [0:LG_N];
    logic [30:0] w_lg_x    [0:LG_N];
    logic [15:0] w_lg_frac [0:LG_N];

    assign w_lg_vld[0]  = r_n_vld;
    assign w_lg_zero[0] = r_n_zero;
    assign w_lg_one[0]  = r_n_one;
    assign w_lg_lead[0] = r_n_lead;
    assign w_lg_x[0]    = r_n_x;
    assign w_lg_frac[0] = '0;

    for (genvar k = 0; k < LG_N; k++) begin : g_log
        logic [61:0] n_sq;
        logic        r_vld, r_zero, r_one;
        logic [3:0]  r_lead;
        logic [30:0] r_x;
        logic [15:0] r_frac;

        assign n_sq = 62'(w_lg_x[k]) * 62'(w_lg_x[k]);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_lg_vld[k];
            end
            r_zero <= w_lg_zero[k];
            r_one  <= w_lg_one[k];
            r_lead <= w_lg_lead[k];
            r_x    <= n_sq[61] ? n_sq[61:31] : n_sq[60:30];
            r_frac <= w_lg_frac[k] | (n_sq[61] ? (16'd1 << (LG_N - 1 - k)) : 16'd0);
        end

        assign w_lg_vld[k+1]  = r_vld;
        assign w_lg_zero[k+1] = r_zero;
        assign w_lg_one[k+1]  = r_one;
        assign w_lg_lead[k+1] = r_lead;
        assign w_lg_x[k+1]    = r_x;
        assign w_lg_frac[k+1] = r_frac;
    end

    // scale by softness
    logic [20:0] n_log;
    logic [32:0] n_e;
    logic        r_e_vld, r_e_zero, r_e_one;
    logic [4:0]  r_e_int;
    logic [15:0] r_e_frac;

    always_comb begin
        n_log = {5'd16 - 5'(w_lg_lead[LG_N]), 16'd0} - 21'(w_lg_frac[LG_N]);
        n_e   = 33'(n_log) * 33'(i_softness) + 33'd128;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else begin
            r_e_vld <= w_lg_vld[LG_N];
        end
        r_e_zero <= w_lg_zero[LG_N] || (n_e[32:24] >= 9'd17);
        r_e_one  <= w_lg_one[LG_N];
        r_e_int  <= n_e[28:24];
        r_e_frac <= n_e[23:8];
    end

    // exp2 of the negated fraction
    logic        w_ex_vld  [0:EX_N];
    logic        w_ex_zero [0:EX_N];
    logic        w_ex_one  [0:EX_N];
    logic [4:0]  w_ex_int  [0:EX_N];
    logic [15:0] w_ex_frac [0:EX_N];
    logic [30:0] w_ex_m    [0:EX_N];

    assign w_ex_vld[0]  = r_e_vld;
    assign w_ex_zero[0] = r_e_zero;
    assign w_ex_one[0]  = r_e_one;
    assign w_ex_int[0]  = r_e_int;
    assign w_ex_frac[0] = r_e_frac;
    assign w_ex_m[0]    = 31'd1 << 30;

    for (genvar k = 0; k < EX_N; k++) begin : g_exp
        localparam logic [29:0] COEF = exp_coef(k + 1);
        logic [60:0] n_prod;
        logic        r_vld, r_zero, r_one;
        logic [4:0]  r_int;
        logic [15:0] r_frac;
        logic [30:0] r_m;

        assign n_prod = 61'(w_ex_m[k]) * 61'(COEF) + (61'd1 << 29);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else begin
                r_vld <= w_ex_vld[k];
            end
            r_zero <= w_ex_zero[k];
            r_one  <= w_ex_one[k];
            r_int  <= w_ex_int[k];
            r_frac <= w_ex_frac[k];
            r_m    <= w_ex_frac[k][EX_N-1-k] ? n_prod[60:30] : w_ex_m[k];
        end

        assign w_ex_vld[k+1]  = r_vld;
        assign w_ex_zero[k+1] = r_zero;
        assign w_ex_one[k+1]  = r_one;
        assign w_ex_int[k+1]  = r_int;
        assign w_ex_frac[k+1] = r_frac;
        assign w_ex_m[k+1]    = r_m;
    end

    // integer part as a rounded shift
    logic [4:0]  n_sh;
    logic [31:0] n_sum;
    logic        r_p_vld;
    logic [16:0] r_p;

    always_comb begin
        n_sh  = w_ex_int[EX_N] + 5'd14;
        n_sum = 32'(w_ex_m[EX_N]) + (32'd1 << (n_sh - 5'd1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= w_ex_vld[EX_N];
        end
        if (w_ex_one[EX_N]) begin
            r_p <= rvp_pkg::Q16_ONE;
        end else if (w_ex_zero[EX_N]) begin
            r_p <= '0;
        end else begin
            r_p <= 17'(n_sum >> n_sh);
        end
    end

    assign o_power.vld = r_p_vld;
    assign o_power.p   = r_p;

endmodule

// ===== rtl/radial_vignette_pixel_unit.sv =====
// Radial vignette pixel unit: configuration registers, smoothstep mask and sample mix.
// Depends on rvp_pkg, rvp_ratio and rvp_power.
//
// One pixel is taken on every clock at which start is high; busy stays low, so the unit
// never refuses a pixel. Each result word appears on o_result0..2 with o_valid for exactly
// one cycle, in input order. The pipeline holds the 32-stage square root, the 16-stage
// radius divide, the 16+16 stage log/exp chain of the exponent with its normalise, scale
// and rounding stages, plus nine stages of distance, mask and mixing arithmetic.
module radial_vignette_pixel_unit #(
    parameter int COORD_BITS   = 12,
    parameter int SAMPLE_BITS  = 16,
    parameter int NUM_CHANNELS = 3
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [COORD_BITS-1:0]  i_pos_x,
    input  logic [COORD_BITS-1:0]  i_pos_y,
    input  logic [SAMPLE_BITS-1:0] i_sample0,
    input  logic [SAMPLE_BITS-1:0] i_sample1,
    input  logic [SAMPLE_BITS-1:0] i_sample2,
    input  logic                   i_cfg_we,
    input  logic [2:0]             i_cfg_index,
    input  logic [16:0]            i_cfg_data,
    output logic                   o_valid,
    output logic [SAMPLE_BITS-1:0] o_result0,
    output logic [SAMPLE_BITS-1:0] o_result1,
    output logic [SAMPLE_BITS-1:0] o_result2
);
    localparam logic [2:0] CFG_CENTER_X  = 3'd0;
    localparam logic [2:0] CFG_CENTER_Y  = 3'd1;
    localparam logic [2:0] CFG_RADIUS    = 3'd2;
    localparam logic [2:0] CFG_SOFTNESS  = 3'd3;
    localparam logic [2:0] CFG_INTENSITY = 3'd4;
    localparam logic [2:0] CFG_MODE      = 3'd5;

    localparam logic [11:0] SOFT_MIN    = 12'd26;
    localparam logic [15:0] RECIP_100   = 16'd41943;
    localparam int          SMP_DLY     = rvp_pkg::RATIO_LAT + rvp_pkg::POWER_LAT + 5;
    localparam int          MW          = SAMPLE_BITS + 17;
    localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

    // configuration
    logic signed [16:0] r_center_x, r_center_y;
    logic [16:0]        r_radius;
    logic [11:0]        r_softness;
    logic signed [7:0]  r_intensity;
    logic               r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= '0;
            r_center_y  <= '0;
            r_radius    <= '0;
            r_softness  <= 12'd256;
            r_intensity <= '0;
            r_mode      <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CENTER_X:  r_center_x  <= signed'(i_cfg_data);
                CFG_CENTER_Y:  r_center_y  <= signed'(i_cfg_data);
                CFG_RADIUS:    r_radius    <= i_cfg_data;
                CFG_SOFTNESS:  r_softness  <= i_cfg_data[11:0];
                CFG_INTENSITY: r_intensity <= signed'(i_cfg_data[7:0]);
                CFG_MODE:      r_mode      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [11:0]       w_soft;
    logic signed [7:0] w_int;
    logic              w_darken;
    logic [6:0]        w_amt;

    always_comb begin
        w_soft = (r_softness < SOFT_MIN) ? SOFT_MIN : r_softness;
        if (r_intensity > 8'sd100) begin
            w_int = 8'sd100;
        end else if (r_intensity < -8'sd100) begin
            w_int = -8'sd100;
        end else begin
            w_int = r_intensity;
        end
        w_darken = w_int[7];
        w_amt    = w_darken ? 7'(-w_int) : 7'(w_int);
    end

    assign busy = 1'b0;

    rvp_pkg::t_ratio w_ratio;
    rvp_pkg::t_power w_power;

    rvp_ratio #(
        .COORD_BITS (COORD_BITS)
    ) u_ratio (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .i_radius   (r_radius),
        .o_ratio    (w_ratio)
    );

    rvp_power u_power (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ratio    (w_ratio),
        .i_softness (w_soft),
        .o_power    (w_power)
    );

    // smoothstep mask and amount
    logic [33:0] n_m2;
    logic [34:0] n_mask;
    logic [38:0] n_qe;
    logic [23:0] n_rem;

    logic        r_m2_vld, r_mk_vld, r_x_vld, r_qe_vld, r_a_vld, r_out_vld;
    logic [16:0] r_m2, r_m2_p, r_mask, r_qe, r_a;
    logic [22:0] r_x, r_qe_x;

    always_comb begin
        n_m2   = 34'(w_power.p) * 34'(w_power.p) + 34'd32768;
        n_mask = 35'(r_m2) * 35'(18'h30000 - {r_m2_p, 1'b0}) + 35'd32768;
        n_qe   = 39'(r_x) * 39'(RECIP_100);
        n_rem  = 24'(r_qe_x) - 24'(r_qe) * 24'd100;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2_vld <= 1'b0;
            r_mk_vld <= 1'b0;
            r_x_vld  <= 1'b0;
            r_qe_vld <= 1'b0;
            r_a_vld  <= 1'b0;
        end else begin
            r_m2_vld <= w_power.vld;
            r_mk_vld <= r_m2_vld;
            r_x_vld  <= r_mk_vld;
            r_qe_vld <= r_x_vld;
            r_a_vld  <= r_qe_vld;
        end
        r_m2   <= n_m2[32:16];
        r_m2_p <= w_power.p;
        r_mask <= n_mask[32:16];
        r_x    <= 23'(w_amt) * 23'(r_mask) + 23'd50;
        r_qe   <= n_qe[38:22];
        r_qe_x <= r_x;
        r_a    <= (n_rem >= 24'd100) ? (r_qe + 17'd1) : r_qe;
    end

    // sample delay and mix
    logic [SAMPLE_BITS-1:0] w_smp_in [0:2];
    logic [SAMPLE_BITS-1:0] w_res    [0:2];

    assign w_smp_in[0] = i_sample0;
    assign w_smp_in[1] = i_sample1;
    assign w_smp_in[2] = i_sample2;

    for (genvar c = 0; c < 3; c++) begin : g_chan
        if (c < NUM_CHANNELS) begin : g_on
            logic [SAMPLE_BITS-1:0] r_smp [0:SMP_DLY-1];
            logic [SAMPLE_BITS-1:0] r_res;
            logic [SAMPLE_BITS-1:0] n_v;
            logic [MW-1:0]          n_dk, n_lt;
            logic                   n_en;

            always_ff @(posedge i_clk) begin
                r_smp[0] <= w_smp_in[c];
                for (int k = 1; k < SMP_DLY; k++) begin
                    r_smp[k] <= r_smp[k-1];
                end
            end

            always_comb begin
                n_v  = r_smp[SMP_DLY-1];
                n_en = (c == 0) || r_mode;
                n_dk = MW'(n_v) * MW'(17'h10000 - r_a) + MW'(32768);
                n_lt = MW'(SMAX - n_v) * MW'(r_a) + MW'(32768);
            end

            always_ff @(posedge i_clk) begin
                if (!n_en) begin
                    r_res <= '0;
                end else if (w_darken) begin
                    r_res <= n_dk[SAMPLE_BITS+15:16];
                end else begin
                    r_res <= n_v + n_lt[SAMPLE_BITS+15:16];
                end
            end

            assign w_res[c] = r_res;
        end else begin : g_off
            assign w_res[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_a_vld;
        end
    end

    assign o_valid   = r_out_vld;
    assign o_result0 = w_res[0];
    assign o_result1 = w_res[1];
    assign o_result2 = w_res[2];

endmodule
